@@ design/idpm_pkg.sv @@
// idpm_pkg: constants, register indexes and shared types of the input
// debounce and power monitor. No dependencies; compile first.
`timescale 1ns / 1ps
package idpm_pkg;

    // Default sizes.
    localparam int NUM_PINS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Field widths fixed by the register map and the result format.
    localparam int TICK_W       = 8;
    localparam int LOST_LEVEL_W = 12;
    localparam int LOW_LEVEL_W  = 10;
    localparam int VOLT_W       = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;

    // Voltage scaling: ((sample * VOLT_MUL) >> VOLT_SHIFT) + VOLT_OFFSET.
    localparam int unsigned VOLT_MUL    = 543;
    localparam int          VOLT_MUL_W  = 10;
    localparam int unsigned VOLT_SHIFT  = 12;
    localparam int unsigned VOLT_OFFSET = 21;
    localparam int unsigned VOLT_MAX    = 1023;

    // Persistence counters saturate here.
    localparam logic [TICK_W-1:0] RUN_MAX = '1;

    // Register reset values.
    localparam logic [TICK_W-1:0]       RST_EMERG_TICKS  = 8'd20;
    localparam logic [TICK_W-1:0]       RST_IGN_TICKS    = 8'd20;
    localparam logic [TICK_W-1:0]       RST_OTHER_TICKS  = 8'd0;
    localparam logic [LOST_LEVEL_W-1:0] RST_LOST_LEVEL   = 12'd500;
    localparam logic [TICK_W-1:0]       RST_LOST_PERSIST = 8'd40;
    localparam logic [LOW_LEVEL_W-1:0]  RST_LOW_LEVEL    = 10'd100;
    localparam logic [TICK_W-1:0]       RST_LOW_PERSIST  = 8'd20;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMERG_TICKS  = 3'd0,
        CFG_IGN_TICKS    = 3'd1,
        CFG_OTHER_TICKS  = 3'd2,
        CFG_LOST_LEVEL   = 3'd3,
        CFG_LOST_PERSIST = 3'd4,
        CFG_LOW_LEVEL    = 3'd5,
        CFG_LOW_PERSIST  = 3'd6
    } t_cfg_idx;

    // Pins with a dedicated role.
    localparam int PIN_EMERG = 0;
    localparam int PIN_IGN   = 1;

endpackage

@@ design/idpm_if.sv @@
// idpm_if: valid/ready channel interfaces for ticks, results and register
// writes of the input debounce and power monitor. Depends on idpm_pkg.
`timescale 1ns / 1ps
interface idpm_in_if #(
    parameter int NUM_PINS    = idpm_pkg::NUM_PINS_DEF,
    parameter int SAMPLE_BITS = idpm_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [NUM_PINS-1:0]    pin_levels;
    logic [SAMPLE_BITS-1:0] battery_sample;

    modport source (output valid, pin_levels, battery_sample, input ready);
    modport sink   (input valid, pin_levels, battery_sample, output ready);
endinterface

interface idpm_out_if #(
    parameter int NUM_PINS = idpm_pkg::NUM_PINS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [NUM_PINS-1:0]         debounced_levels;
    logic [NUM_PINS-1:0]         changed_mask;
    logic                        emergency_alarm;
    logic                        ignition_on;
    logic                        power_lost;
    logic                        power_low;
    logic [idpm_pkg::VOLT_W-1:0] battery_voltage;

    modport source (output valid, debounced_levels, changed_mask, emergency_alarm,
                    ignition_on, power_lost, power_low, battery_voltage,
                    input ready);
    modport sink   (input valid, debounced_levels, changed_mask, emergency_alarm,
                    ignition_on, power_lost, power_low, battery_voltage,
                    output ready);
endinterface

interface idpm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [idpm_pkg::CFG_IDX_W-1:0]  index;
    logic [idpm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/input_debounce_power_monitor.sv @@
// input_debounce_power_monitor: per-tick pin debounce with supply alarms.
// Depends on idpm_pkg and the channel interfaces in idpm_if.
`timescale 1ns / 1ps
//
//  channel  | dir | word                                         | accepted when
//  ---------+-----+----------------------------------------------+-------------------
//  i_in     | in  | pin_levels, battery_sample (one tick)        | valid && ready
//  o_out    | out | levels, changed mask, four alarms, voltage   | valid && ready
//  i_cfg    | in  | register index, data                         | valid && ready
//
//  A tick is captured in the input register, then the debounce and supply
//  logic updates state and loads the result register. One word per cycle is
//  sustained unless o_out stalls. The result register frees the input side, so
//  a new tick is taken while a result waits; only a stalled result with a full
//  input register holds i_in.ready low. Reset restores register defaults and
//  clears levels, counters and alarms. i_cfg is always ready.
module input_debounce_power_monitor #(
    parameter int NUM_PINS    = idpm_pkg::NUM_PINS_DEF,
    parameter int SAMPLE_BITS = idpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idpm_in_if.sink     i_in,
    idpm_out_if.source  o_out,
    idpm_cfg_if.sink    i_cfg
);
    import idpm_pkg::*;

    // Product width for the voltage scaling and a common width for the
    // raw-sample compare.
    localparam int PROD_W = SAMPLE_BITS + VOLT_MUL_W;
    localparam int CMP_W  = (SAMPLE_BITS > LOST_LEVEL_W) ? SAMPLE_BITS : LOST_LEVEL_W;

    // Configuration registers.
    logic [TICK_W-1:0]       r_emerg_ticks;
    logic [TICK_W-1:0]       r_ign_ticks;
    logic [TICK_W-1:0]       r_other_ticks;
    logic [LOST_LEVEL_W-1:0] r_lost_level;
    logic [TICK_W-1:0]       r_lost_persist;
    logic [LOW_LEVEL_W-1:0]  r_low_level;
    logic [TICK_W-1:0]       r_low_persist;

    // Input register.
    logic                   r_in_vld;
    logic [NUM_PINS-1:0]    r_in_pins;
    logic [SAMPLE_BITS-1:0] r_in_sample;

    // Debounce and supply state.
    logic [NUM_PINS-1:0] r_stable;
    logic [NUM_PINS-1:0] n_stable;
    logic [TICK_W-1:0]   r_mis_cnt [NUM_PINS];
    logic [TICK_W-1:0]   n_mis_cnt [NUM_PINS];
    logic [TICK_W-1:0]   r_lost_run;
    logic [TICK_W-1:0]   n_lost_run;
    logic [TICK_W-1:0]   r_low_run;
    logic [TICK_W-1:0]   n_low_run;
    logic                r_emerg_flag;
    logic                n_emerg_flag;
    logic                r_ign_flag;
    logic                n_ign_flag;
    logic                r_lost_flag;
    logic                n_lost_flag;
    logic                r_low_flag;
    logic                n_low_flag;

    // Result register.
    logic                r_out_vld;
    logic [NUM_PINS-1:0] r_out_levels;
    logic [NUM_PINS-1:0] r_out_changed;
    logic [VOLT_W-1:0]   r_out_volt;

    logic                advance;
    logic [NUM_PINS-1:0] changed;
    logic [NUM_PINS-1:0] accept;
    logic [PROD_W-1:0]   volt_prod;
    logic [PROD_W-1:0]   volt_sum;
    logic [VOLT_W-1:0]   volt;
    logic                lost_cond;
    logic                low_cond;

    // Move the held tick on when the result register is empty or draining.
    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign i_cfg.ready = 1'b1;

    // Register writes; indexes past the map are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emerg_ticks  <= RST_EMERG_TICKS;
            r_ign_ticks    <= RST_IGN_TICKS;
            r_other_ticks  <= RST_OTHER_TICKS;
            r_lost_level   <= RST_LOST_LEVEL;
            r_lost_persist <= RST_LOST_PERSIST;
            r_low_level    <= RST_LOW_LEVEL;
            r_low_persist  <= RST_LOW_PERSIST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_EMERG_TICKS:  r_emerg_ticks  <= i_cfg.data[TICK_W-1:0];
                CFG_IGN_TICKS:    r_ign_ticks    <= i_cfg.data[TICK_W-1:0];
                CFG_OTHER_TICKS:  r_other_ticks  <= i_cfg.data[TICK_W-1:0];
                CFG_LOST_LEVEL:   r_lost_level   <= i_cfg.data[LOST_LEVEL_W-1:0];
                CFG_LOST_PERSIST: r_lost_persist <= i_cfg.data[TICK_W-1:0];
                CFG_LOW_LEVEL:    r_low_level    <= i_cfg.data[LOW_LEVEL_W-1:0];
                CFG_LOW_PERSIST:  r_low_persist  <= i_cfg.data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-pin debounce. Each pin is independent: clear on match, count on
    // mismatch, flip once the count reaches the pin's threshold (at once for
    // a threshold of zero).
    always_comb begin
        logic [TICK_W-1:0] th;
        logic [TICK_W:0]   cnt;
        n_stable     = r_stable;
        n_emerg_flag = r_emerg_flag;
        n_ign_flag   = r_ign_flag;
        accept       = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
            if (i == PIN_EMERG) begin
                th = r_emerg_ticks;
            end else if (i == PIN_IGN) begin
                th = r_ign_ticks;
            end else begin
                th = r_other_ticks;
            end
            cnt          = {1'b0, r_mis_cnt[i]} + 1'b1;
            n_mis_cnt[i] = r_mis_cnt[i];
            if (r_in_pins[i] == r_stable[i]) begin
                n_mis_cnt[i] = '0;
            end else if (th == '0) begin
                accept[i] = 1'b1;
            end else if (cnt >= {1'b0, th}) begin
                accept[i] = 1'b1;
            end else begin
                // cnt stays below th here, so it fits the counter.
                n_mis_cnt[i] = cnt[TICK_W-1:0];
            end
            if (accept[i]) begin
                n_mis_cnt[i] = '0;
                n_stable[i]  = r_in_pins[i];
            end
        end
        // Emergency alarm is active low on its pin; ignition follows its pin.
        if (accept[PIN_EMERG]) begin
            n_emerg_flag = !r_in_pins[PIN_EMERG];
        end
        if (accept[PIN_IGN]) begin
            n_ign_flag = r_in_pins[PIN_IGN];
        end
        changed = accept;
    end

    // Supply voltage and the two persistence alarms.
    always_comb begin
        volt_prod = PROD_W'(r_in_sample) * PROD_W'(VOLT_MUL);
        volt_sum  = (volt_prod >> VOLT_SHIFT) + PROD_W'(VOLT_OFFSET);
        if (volt_sum > PROD_W'(VOLT_MAX)) begin
            volt = VOLT_W'(VOLT_MAX);
        end else begin
            volt = volt_sum[VOLT_W-1:0];
        end

        lost_cond = CMP_W'(r_in_sample) < CMP_W'(r_lost_level);
        low_cond  = volt < r_low_level;

        // Count runs with saturation; set the alarm once the run is long
        // enough, drop it as soon as the condition ends.
        n_lost_flag = r_lost_flag;
        if (lost_cond) begin
            n_lost_run = (r_lost_run == RUN_MAX) ? r_lost_run : r_lost_run + 1'b1;
            if (n_lost_run >= r_lost_persist) begin
                n_lost_flag = 1'b1;
            end
        end else begin
            n_lost_run  = '0;
            n_lost_flag = 1'b0;
        end

        n_low_flag = r_low_flag;
        if (low_cond) begin
            n_low_run = (r_low_run == RUN_MAX) ? r_low_run : r_low_run + 1'b1;
            if (n_low_run >= r_low_persist) begin
                n_low_flag = 1'b1;
            end
        end else begin
            n_low_run  = '0;
            n_low_flag = 1'b0;
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_stable     <= '0;
            r_lost_run   <= '0;
            r_low_run    <= '0;
            r_emerg_flag <= 1'b0;
            r_ign_flag   <= 1'b0;
            r_lost_flag  <= 1'b0;
            r_low_flag   <= 1'b0;
            for (int i = 0; i < NUM_PINS; i++) begin
                r_mis_cnt[i] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_stable     <= n_stable;
                r_lost_run   <= n_lost_run;
                r_low_run    <= n_low_run;
                r_emerg_flag <= n_emerg_flag;
                r_ign_flag   <= n_ign_flag;
                r_lost_flag  <= n_lost_flag;
                r_low_flag   <= n_low_flag;
                for (int i = 0; i < NUM_PINS; i++) begin
                    r_mis_cnt[i] <= n_mis_cnt[i];
                end
            end
        end
    end

    // Payload registers: capture the tick, load the result on advance.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_pins   <= i_in.pin_levels;
            r_in_sample <= i_in.battery_sample;
        end
        if (advance) begin
            r_out_levels  <= n_stable;
            r_out_changed <= changed;
            r_out_volt    <= volt;
        end
    end

    // Alarm flags are state and already hold this tick's values once the
    // result is loaded; later ticks cannot pass a waiting result.
    assign o_out.valid            = r_out_vld;
    assign o_out.debounced_levels = r_out_levels;
    assign o_out.changed_mask     = r_out_changed;
    assign o_out.emergency_alarm  = r_emerg_flag;
    assign o_out.ignition_on      = r_ign_flag;
    assign o_out.power_lost       = r_lost_flag;
    assign o_out.power_low        = r_low_flag;
    assign o_out.battery_voltage  = r_out_volt;

endmodule
